[design/hbf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hbf_pkg
// Types, codes and helpers shared by the HTTP body framer and its checker.
// ----------------------------------------------------------------------------
package hbf_pkg;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic       OP_BYTE  = 1'b0;
  localparam logic       OP_START = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_FIXED    = 4'd1,
    PH_SIZE     = 4'd2,
    PH_SIZE_LF  = 4'd3,
    PH_DATA     = 4'd4,
    PH_CHUNK_CR = 4'd5,
    PH_CHUNK_LF = 4'd6,
    PH_ZERO_CR  = 4'd7,
    PH_ZERO_LF  = 4'd8
  } hbf_phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FINAL    = 3'd1,
    ST_CHUNK    = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_IDLE     = 3'd4
  } hbf_status_t;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  data_byte;
    logic        chunked_mode;
    logic [31:0] body_length;
  } hbf_in_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        body_end;
    hbf_status_t status;
  } hbf_out_t;

  // {is_hex, value}
  function automatic logic [4:0] hbf_hex(input logic [7:0] c);
    logic [4:0] res;
    case (c) inside
      [8'h30:8'h39]: res = {1'b1, 4'(c - 8'h30)};
      [8'h61:8'h66]: res = {1'b1, 4'(c - 8'h57)};
      [8'h41:8'h46]: res = {1'b1, 4'(c - 8'h37)};
      default:       res = 5'd0;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

[design/http_body_framer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// http_body_framer
// Frames one HTTP/1.x message body, fixed length or chunked, from a byte stream.
// ----------------------------------------------------------------------------
// Every request yields exactly one result. A request is decoded in the cycle
// it is taken and its result is registered, so the block takes one request
// per clock as long as results are drained; a one-entry skid stage behind the
// result register keeps input open for one more request when the result side
// stalls. Chunk sizes are limited to SIZE_BITS bits; a larger size reports an
// overflow and the block goes idle, as it does on any framing error.
module http_body_framer
  import hbf_pkg::*;
#(
  parameter int SIZE_BITS = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire hbf_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output hbf_out_t      out_data
);

  localparam int CNT_BITS = (SIZE_BITS > 32) ? SIZE_BITS : 32;

  hbf_phase_t            phase_r, phase_nxt;
  logic [CNT_BITS-1:0]   bytes_left_r, bytes_left_nxt;
  logic [SIZE_BITS-1:0]  size_accum_r, size_accum_nxt;
  logic                  digits_open_r, digits_open_nxt;

  logic                  out_valid_r, skid_valid_r;
  hbf_out_t              out_data_r, skid_data_r;
  hbf_out_t              res;

  logic                  in_fire, out_fire;
  logic [CNT_BITS-1:0]   left_dec;
  logic [4:0]            hex;

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign left_dec  = bytes_left_r - CNT_BITS'(1);
  assign hex       = hbf_hex(in_data.data_byte);

  always_comb begin
    phase_nxt       = phase_r;
    bytes_left_nxt  = bytes_left_r;
    size_accum_nxt  = size_accum_r;
    digits_open_nxt = digits_open_r;
    res             = '0;
    res.status      = ST_OK;

    if (in_data.opcode == OP_START) begin
      phase_nxt       = PH_IDLE;
      bytes_left_nxt  = '0;
      size_accum_nxt  = '0;
      digits_open_nxt = 1'b0;
      if (in_data.chunked_mode) begin
        phase_nxt       = PH_SIZE;
        digits_open_nxt = 1'b1;
      end else if (in_data.body_length == 32'd0) begin
        res.body_end = 1'b1;
      end else begin
        phase_nxt      = PH_FIXED;
        bytes_left_nxt = CNT_BITS'(in_data.body_length);
      end
    end else begin
      case (phase_r)
        PH_FIXED: begin
          res.payload_byte  = in_data.data_byte;
          res.payload_valid = 1'b1;
          bytes_left_nxt    = left_dec;
          if (left_dec == '0) begin
            res.body_end    = 1'b1;
            phase_nxt       = PH_IDLE;
            size_accum_nxt  = '0;
            digits_open_nxt = 1'b0;
          end
        end
        PH_SIZE, PH_SIZE_LF: begin
          if (phase_r == PH_SIZE_LF && in_data.data_byte == CH_LF) begin
            if (size_accum_r == '0) begin
              phase_nxt = PH_ZERO_CR;
            end else begin
              bytes_left_nxt = CNT_BITS'(size_accum_r);
              phase_nxt      = PH_DATA;
            end
            digits_open_nxt = 1'b0;
          end else if (in_data.data_byte == CH_CR) begin
            digits_open_nxt = 1'b0;
            phase_nxt       = PH_SIZE_LF;
          end else begin
            phase_nxt = PH_SIZE;
            if (digits_open_r && hex[4]) begin
              if (size_accum_r[SIZE_BITS-1 -: 4] != 4'd0) begin
                res.status      = ST_OVERFLOW;
                phase_nxt       = PH_IDLE;
                bytes_left_nxt  = '0;
                size_accum_nxt  = '0;
                digits_open_nxt = 1'b0;
              end else begin
                size_accum_nxt = {size_accum_r[SIZE_BITS-5:0], hex[3:0]};
              end
            end else begin
              digits_open_nxt = 1'b0;
            end
          end
        end
        PH_DATA: begin
          res.payload_byte  = in_data.data_byte;
          res.payload_valid = 1'b1;
          bytes_left_nxt    = left_dec;
          if (left_dec == '0) begin
            phase_nxt = PH_CHUNK_CR;
          end
        end
        PH_CHUNK_CR, PH_CHUNK_LF, PH_ZERO_CR: begin
          if (phase_r == PH_CHUNK_CR && in_data.data_byte == CH_CR) begin
            phase_nxt = PH_CHUNK_LF;
          end else if (phase_r == PH_ZERO_CR && in_data.data_byte == CH_CR) begin
            phase_nxt = PH_ZERO_LF;
          end else if (phase_r == PH_CHUNK_LF && in_data.data_byte == CH_LF) begin
            phase_nxt       = PH_SIZE;
            size_accum_nxt  = '0;
            digits_open_nxt = 1'b1;
          end else begin
            res.status      = (phase_r == PH_ZERO_CR) ? ST_FINAL : ST_CHUNK;
            phase_nxt       = PH_IDLE;
            bytes_left_nxt  = '0;
            size_accum_nxt  = '0;
            digits_open_nxt = 1'b0;
          end
        end
        PH_ZERO_LF: begin
          if (in_data.data_byte == CH_LF) begin
            res.body_end = 1'b1;
          end else begin
            res.status = ST_FINAL;
          end
          phase_nxt       = PH_IDLE;
          bytes_left_nxt  = '0;
          size_accum_nxt  = '0;
          digits_open_nxt = 1'b0;
        end
        default: begin
          // byte with no open body
          res.status      = ST_IDLE;
          phase_nxt       = PH_IDLE;
          bytes_left_nxt  = '0;
          size_accum_nxt  = '0;
          digits_open_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      bytes_left_r  <= '0;
      size_accum_r  <= '0;
      digits_open_r <= 1'b0;
    end else if (in_fire) begin
      phase_r       <= phase_nxt;
      bytes_left_r  <= bytes_left_nxt;
      size_accum_r  <= size_accum_nxt;
      digits_open_r <= digits_open_nxt;
    end
  end

  // result register with a one-entry skid behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_fire) begin
      if (skid_valid_r) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else if (in_fire) begin
        out_data_r <= res;
      end else begin
        out_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r) begin
        out_data_r  <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= res;
        skid_valid_r <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[design/hbf_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hbf_checker
// Port-level assertions for the HTTP body framer.
// ----------------------------------------------------------------------------
module hbf_checker
  import hbf_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire hbf_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire hbf_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input only closes when a result is already waiting
  a_ready_skid: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !$past(out_ready))
    else $error("input closed without a stalled result");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      !out_data.payload_valid && !out_data.body_end && out_data.payload_byte == 8'd0)
    else $error("error result carries payload");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.payload_valid |-> out_data.payload_byte == 8'd0)
    else $error("non-payload result with nonzero byte");

  // a start request gives a clean result next cycle when nothing waits
  a_start_ok: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid && in_data.opcode == OP_START |=>
      out_valid && out_data.status == ST_OK && !out_data.payload_valid)
    else $error("start request gave bad result");

endmodule

bind http_body_framer hbf_checker u_hbf_checker (.*);
`default_nettype wire
